FILE: rtl/plsu_pkg.sv
package plsu_pkg;

  localparam logic [2:0] KIND_INS_FRONT = 3'd0;
  localparam logic [2:0] KIND_INS_BACK  = 3'd1;
  localparam logic [2:0] KIND_INS_POS   = 3'd2;
  localparam logic [2:0] KIND_DEL_FRONT = 3'd3;
  localparam logic [2:0] KIND_DEL_BACK  = 3'd4;
  localparam logic [2:0] KIND_DEL_POS   = 3'd5;
  localparam logic [2:0] KIND_SHOW      = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  position;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] element;
    logic [6:0]  element_index;
    logic [6:0]  length;
    logic        last;
  } rsp_t;

endpackage

FILE: rtl/positional_list_store_unit.sv
// order: a rejected or unused command answers in the cycle after the accepting edge; an insert
// or delete copies each moved element through the element ram, then an insert writes its value,
// and the result follows; display gives one beat per element, each from a ram read of it
// throughput: one command at a time; the copy loop through the element ram reads one element
// and writes the one read before it every cycle
// reset: synchronous, clears the length and control state; the ram is not cleared
// results are one-cycle strobes on rsp_valid and the receiver cannot stall them
module positional_list_store_unit
  import plsu_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic rsp_valid,
  output rsp_t rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {IDLE, SHIFT_UP, SHIFT_DN, SHOW} state_t;

  state_t          state;
  logic [LW-1:0]   len;
  logic [AW-1:0]   cur;
  logic [AW-1:0]   slot;
  logic [AW-1:0]   wtgt;
  logic [LW-1:0]   pidx;
  logic            pend;
  logic            more;
  logic [DATA_WIDTH-1:0] val;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic [LW-1:0] cur_inc;
  logic          full;
  logic          empty;
  logic          ins_pos_ok;
  logic          del_pos_ok;
  logic [1:0]    dec_status;
  state_t        dec_state;
  logic [AW-1:0] dec_slot;

  assign busy    = (state != IDLE);
  assign cur_inc = LW'(cur) + LW'(1);
  assign full    = (len == LW'(CAPACITY));
  assign empty   = (len == '0);
  assign ins_pos_ok = (req.position != 8'd0) && ({1'b0, req.position} <= 9'(len) + 9'd1);
  assign del_pos_ok = (req.position != 8'd0) && ({1'b0, req.position} <= 9'(len));

  always_comb begin
    dec_status = ST_OK;
    dec_state  = IDLE;
    dec_slot   = '0;
    unique case (req.kind)
      KIND_INS_FRONT: begin
        if (full) dec_status = ST_FULL;
        else dec_state = SHIFT_UP;
      end
      KIND_INS_BACK: begin
        dec_slot = AW'(len);
        if (full) dec_status = ST_FULL;
        else dec_state = SHIFT_UP;
      end
      KIND_INS_POS: begin
        dec_slot = AW'(req.position - 8'd1);
        if (!ins_pos_ok) dec_status = ST_RANGE;
        else if (full) dec_status = ST_FULL;
        else dec_state = SHIFT_UP;
      end
      KIND_DEL_FRONT: begin
        if (empty) dec_status = ST_EMPTY;
        else dec_state = SHIFT_DN;
      end
      KIND_DEL_BACK: begin
        dec_slot = AW'(len - LW'(1));
        if (empty) dec_status = ST_EMPTY;
        else dec_state = SHIFT_DN;
      end
      KIND_DEL_POS: begin
        dec_slot = AW'(req.position - 8'd1);
        if (empty) dec_status = ST_EMPTY;
        else if (!del_pos_ok) dec_status = ST_RANGE;
        else dec_state = SHIFT_DN;
      end
      KIND_SHOW: begin
        if (empty) dec_status = ST_EMPTY;
        else dec_state = SHOW;
      end
      default: ;
    endcase
  end

  // ram port control: the copy beat read last cycle is written while the next one is read
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wtgt;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = cur;
    unique case (state)
      SHIFT_UP: begin
        if (pend) ram_we = 1'b1;
        if (cur != slot) begin
          ram_re    = 1'b1;
          ram_raddr = cur - AW'(1);
        end else if (!pend) begin
          ram_we    = 1'b1;
          ram_waddr = slot;
          ram_wdata = val;
        end
      end
      SHIFT_DN: begin
        if (pend) ram_we = 1'b1;
        if (cur_inc < len) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(cur_inc);
        end
      end
      SHOW: begin
        ram_re = more;
      end
      default: ;
    endcase
  end

  plsu_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      len       <= '0;
      pend      <= 1'b0;
      more      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            val   <= DATA_WIDTH'(req.value);
            slot  <= dec_slot;
            pend  <= 1'b0;
            more  <= 1'b1;
            state <= dec_state;
            if (dec_state == SHIFT_DN) cur <= dec_slot;
            else if (dec_state == SHOW) cur <= '0;
            else cur <= AW'(len);
            if (dec_state == IDLE) begin
              rsp_valid         <= 1'b1;
              rsp.status        <= dec_status;
              rsp.element       <= '0;
              rsp.element_index <= '0;
              rsp.length        <= 7'(len);
              rsp.last          <= 1'b1;
            end
          end
        end
        SHIFT_UP: begin
          if (cur != slot) begin
            wtgt <= cur;
            cur  <= cur - AW'(1);
            pend <= 1'b1;
          end else if (!pend) begin
            len               <= len + LW'(1);
            state             <= IDLE;
            rsp_valid         <= 1'b1;
            rsp.status        <= ST_OK;
            rsp.element       <= '0;
            rsp.element_index <= '0;
            rsp.length        <= 7'(len + LW'(1));
            rsp.last          <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
        end
        SHIFT_DN: begin
          if (cur_inc < len) begin
            wtgt <= cur;
            cur  <= AW'(cur_inc);
            pend <= 1'b1;
          end else if (!pend) begin
            len               <= len - LW'(1);
            state             <= IDLE;
            rsp_valid         <= 1'b1;
            rsp.status        <= ST_OK;
            rsp.element       <= '0;
            rsp.element_index <= '0;
            rsp.length        <= 7'(len - LW'(1));
            rsp.last          <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
        end
        SHOW: begin
          if (more) begin
            pidx <= cur_inc;
            pend <= 1'b1;
            if (cur_inc == len) more <= 1'b0;
            else cur <= AW'(cur_inc);
          end else begin
            pend <= 1'b0;
          end
          // element read last beat goes out now
          if (pend) begin
            rsp_valid         <= 1'b1;
            rsp.status        <= ST_OK;
            rsp.element       <= 32'(ram_rdata);
            rsp.element_index <= 7'(pidx);
            rsp.length        <= 7'(len);
            rsp.last          <= (pidx == len);
            if (pidx == len) state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(CAPACITY))
    else $error("list length beyond capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == IDLE |-> !ram_we)
    else $error("ram written while idle");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.last |-> state == IDLE)
    else $error("final result while command still running");

  a_pend_busy: assert property (@(posedge clk) disable iff (rst)
    pend |-> state != IDLE)
    else $error("copy beat pending while idle");

  a_index_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.element_index == 7'd0)
    else $error("element index on a failed result");

endmodule

FILE: rtl/plsu_ram.sv
module plsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
